// ===== hw/rtl/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg: shared types and constants of the floppy controller command unit
// Payload structs, register indexes, command nibbles, status bits and the
// controller state type.
// ----------------------------------------------------------------------------
package fdc_pkg;

  // Sizing
  localparam int NUM_DRIVES_DEF = 2;
  localparam int DMA_W          = 24;
  localparam int DMA_ADDR_BITS  = 24;
  localparam logic [DMA_W-1:0] DMA_MASK =
    (DMA_ADDR_BITS >= DMA_W) ? {DMA_W{1'b1}}
                             : DMA_W'((64'd1 << DMA_ADDR_BITS) - 64'd1);

  // APB register port
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_A_SIDES   = 3'd0;
  localparam logic [2:0] REG_A_TRACKS  = 3'd1;
  localparam logic [2:0] REG_A_SECTORS = 3'd2;
  localparam logic [2:0] REG_A_BYTES   = 3'd3;
  localparam logic [2:0] REG_B_SIDES   = 3'd4;
  localparam logic [2:0] REG_B_TRACKS  = 3'd5;
  localparam logic [2:0] REG_B_SECTORS = 3'd6;
  localparam logic [2:0] REG_B_BYTES   = 3'd7;

  // Register reset values
  localparam logic [1:0]  RST_SIDES   = 2'd2;
  localparam logic [7:0]  RST_TRACKS  = 8'd80;
  localparam logic [5:0]  RST_SECTORS = 6'd9;
  localparam logic [10:0] RST_BYTES   = 11'd512;

  // Command upper nibbles
  localparam logic [3:0] OP_RESTORE  = 4'h0;
  localparam logic [3:0] OP_SEEK     = 4'h1;
  localparam logic [3:0] OP_STEP     = 4'h2;
  localparam logic [3:0] OP_STEP_U   = 4'h3;
  localparam logic [3:0] OP_STEP_IN  = 4'h4;
  localparam logic [3:0] OP_STEP_INU = 4'h5;
  localparam logic [3:0] OP_STEP_OUT = 4'h6;
  localparam logic [3:0] OP_STEP_OTU = 4'h7;
  localparam logic [3:0] OP_RD_MULTI = 4'h9;
  localparam logic [3:0] OP_WR_SINGL = 4'hA;
  localparam logic [3:0] OP_WR_MULTI = 4'hB;
  localparam logic [3:0] OP_FORCE    = 4'hD;

  localparam logic [7:0] CMD_FORCE_CLR = 8'hD0;
  localparam logic [7:0] CMD_FORCE_SET = 8'hD8;

  // Status bits
  localparam logic [7:0] ST_TRACK0 = 8'h04;
  localparam logic [7:0] ST_ERROR  = 8'h10;
  localparam logic [7:0] ST_SPINUP = 8'h20;
  localparam logic [7:0] ST_MOTOR  = 8'h80;

  // Transfer kinds and drive codes
  localparam logic [1:0] XFER_NONE  = 2'd0;
  localparam logic [1:0] XFER_READ  = 2'd1;
  localparam logic [1:0] XFER_WRITE = 2'd2;
  localparam logic [1:0] DRV_NONE   = 2'd2;

  // Block size and ratio divider
  localparam int          BLOCK_SHIFT   = 9;
  localparam logic [9:0]  BLOCK_BYTES   = 10'd512;
  localparam int          DIV_BITS_STEP = 2;
  localparam int          DIV_STEPS     = 5;

  typedef struct packed {
    logic [7:0]       command_byte;
    logic [7:0]       data_value;
    logic [7:0]       track_value;
    logic [7:0]       sector_value;
    logic [2:0]       select_lines;
    logic [DMA_W-1:0] dma_address;
    logic [7:0]       dma_sector_count;
    logic             medium_ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       status_value;
    logic [7:0]       track_out;
    logic [7:0]       sector_out;
    logic [DMA_W-1:0] dma_address_out;
    logic [7:0]       dma_count_out;
    logic             dma_done;
    logic [1:0]       transfer_kind;
    logic [31:0]      byte_offset;
    logic [16:0]      byte_count;
    logic [1:0]       drive_index;
    logic             force_int_flag;
  } res_t;

  typedef struct packed {
    logic [1:0]  sides;
    logic [7:0]  tracks;
    logic [5:0]  sectors;
    logic [10:0] sbytes;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_FIN
  } fsm_t;

endpackage

// ===== hw/rtl/fdc_if.sv =====
// ----------------------------------------------------------------------------
// fdc_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fdc_cmd_if import fdc_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fdc_res_if import fdc_pkg::*; ();
  logic valid;
  logic ready;
  res_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/fdc_regs.sv =====
// ----------------------------------------------------------------------------
// fdc_regs: medium geometry registers
// APB-style register file holding sides, tracks, sectors and sector size
// for both drives.
// ----------------------------------------------------------------------------
module fdc_regs import fdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t [1:0]        cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < 2; d++) begin
        cfg[d].sides   <= RST_SIDES;
        cfg[d].tracks  <= RST_TRACKS;
        cfg[d].sectors <= RST_SECTORS;
        cfg[d].sbytes  <= RST_BYTES;
      end
    end else if (wr_en) begin
      unique case (idx)
        REG_A_SIDES:   cfg[0].sides   <= pwdata[1:0];
        REG_A_TRACKS:  cfg[0].tracks  <= pwdata[7:0];
        REG_A_SECTORS: cfg[0].sectors <= pwdata[5:0];
        REG_A_BYTES:   cfg[0].sbytes  <= pwdata[10:0];
        REG_B_SIDES:   cfg[1].sides   <= pwdata[1:0];
        REG_B_TRACKS:  cfg[1].tracks  <= pwdata[7:0];
        REG_B_SECTORS: cfg[1].sectors <= pwdata[5:0];
        REG_B_BYTES:   cfg[1].sbytes  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_A_SIDES:   prdata = APB_DW'(cfg[0].sides);
      REG_A_TRACKS:  prdata = APB_DW'(cfg[0].tracks);
      REG_A_SECTORS: prdata = APB_DW'(cfg[0].sectors);
      REG_A_BYTES:   prdata = APB_DW'(cfg[0].sbytes);
      REG_B_SIDES:   prdata = APB_DW'(cfg[1].sides);
      REG_B_TRACKS:  prdata = APB_DW'(cfg[1].tracks);
      REG_B_SECTORS: prdata = APB_DW'(cfg[1].sectors);
      REG_B_BYTES:   prdata = APB_DW'(cfg[1].sbytes);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/fdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdc_ctrl: command sequencer
// Takes a command beat, runs the datapath for the divider steps, then
// commits the result into the output register once it is free.
// ----------------------------------------------------------------------------
module fdc_ctrl import fdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_ctl_t ctl
);

  localparam int CW = $clog2(DIV_STEPS);

  fsm_t          state, state_next;
  logic [CW-1:0] step_cnt;
  logic          fin_go;

  assign fin_go = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_BUSY;
      S_BUSY: if (step_cnt == CW'(DIV_STEPS - 1)) state_next = S_FIN;
      S_FIN:  if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs; no beat is taken while reset is high
  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        ctl.load = in_valid && !rst;
      end
      S_BUSY: ctl.step = 1'b1;
      S_FIN:  ctl.commit = fin_go;
      default: ;
    endcase
  end

  // State, step counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_BUSY) begin
        step_cnt <= step_cnt + CW'(1);
      end else begin
        step_cnt <= '0;
      end
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/fdc_dp.sv =====
// ----------------------------------------------------------------------------
// fdc_dp: command datapath
// Latches a command, computes the medium offset over a short multiplier
// chain, divides 512 by the sector size two bits a step, and on commit
// updates head, direction and force flag and writes the result register.
// ----------------------------------------------------------------------------
module fdc_dp import fdc_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_ctl_t    ctl,
  input  cmd_t       cmd_in,
  input  cfg_t [1:0] cfg,
  output res_t       res
);

  localparam int DW = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

  // State
  logic [15:0] head [NUM_DRIVES];
  logic        step_dir;
  logic        force_flag;

  // Latched command and working registers
  cmd_t        cmd_q;
  logic [7:0]  ss_q;
  logic [31:0] p1_q;
  logic [31:0] lin_q;
  logic [31:0] off_q;
  logic [10:0] rem_q;
  logic [9:0]  dvd_q;
  logic [9:0]  quo_q;

  // Decode
  logic [2:0]  sel;
  logic        side, drv_a, drv_b, drv_ok;
  logic [DW-1:0] hidx;
  cfg_t        c;
  logic [15:0] h_cur;
  logic [3:0]  nib;
  logic        is_t1, is_force, is_xfer, is_multi, ok;

  assign sel    = ~cmd_q.select_lines;
  assign side   = sel[0];
  assign drv_a  = (sel[2:1] == 2'b01);
  assign drv_b  = (sel[2:1] == 2'b10) && (NUM_DRIVES > 1);
  assign drv_ok = drv_a | drv_b;
  assign hidx   = DW'(drv_b);
  assign c      = cfg[drv_b];
  assign h_cur  = drv_ok ? head[hidx] : 16'd0;
  assign nib    = cmd_q.command_byte[7:4];
  assign ok     = cmd_q.medium_ok;
  assign is_t1    = !cmd_q.command_byte[7];
  assign is_force = (nib == OP_FORCE);
  assign is_xfer  = cmd_q.command_byte[7] && drv_ok && (nib <= OP_WR_MULTI);
  assign is_multi = (nib == OP_RD_MULTI) || (nib == OP_WR_MULTI);

  // Offset chain products
  logic signed [24:0] p1_prod;
  assign p1_prod = $signed({1'b0, ss_q}) * $signed(h_cur);

  // Ratio divider: two quotient bits per step
  logic [11:0] dv_t;
  logic [10:0] dv_r;
  logic [9:0]  dv_d, dv_q;
  always_comb begin
    dv_r = rem_q;
    dv_d = dvd_q;
    dv_q = quo_q;
    dv_t = '0;
    for (int k = 0; k < DIV_BITS_STEP; k++) begin
      dv_t = {dv_r, dv_d[9]};
      dv_d = {dv_d[8:0], 1'b0};
      if (dv_t >= {1'b0, c.sbytes}) begin
        dv_t = dv_t - {1'b0, c.sbytes};
        dv_q = {dv_q[8:0], 1'b1};
      end else begin
        dv_q = {dv_q[8:0], 1'b0};
      end
      dv_r = dv_t[10:0];
    end
  end

  // Load and step registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd_in;
      rem_q <= '0;
      dvd_q <= BLOCK_BYTES;
      quo_q <= '0;
    end else if (ctl.step) begin
      ss_q  <= 8'(c.sectors * c.sides);
      p1_q  <= {{7{p1_prod[24]}}, p1_prod};
      lin_q <= p1_q + (side ? 32'(c.sectors) : 32'd0)
               + 32'(cmd_q.sector_value) - 32'd1;
      off_q <= lin_q * {21'b0, c.sbytes};
      rem_q <= dv_r;
      dvd_q <= dv_d;
      quo_q <= dv_q;
    end
  end

  // Type-I head and track update
  logic [15:0] h_step, seek_sum, h_new, trk16;
  logic [7:0]  trk_new;
  logic        dir_new;
  assign trk16    = {8'b0, c.tracks};
  assign h_step   = step_dir ? (h_cur - 16'd1) : (h_cur + 16'd1);
  assign seek_sum = h_cur + {8'b0, cmd_q.data_value} - {8'b0, cmd_q.track_value};

  always_comb begin
    h_new   = h_cur;
    trk_new = cmd_q.track_value;
    dir_new = step_dir;
    unique case (nib)
      OP_RESTORE: begin
        h_new   = '0;
        trk_new = '0;
      end
      OP_SEEK: begin
        trk_new = cmd_q.data_value;
        if ($signed(seek_sum) < 0 || $signed(seek_sum) >= $signed(trk16)) begin
          h_new = '0;
        end else begin
          h_new = seek_sum;
        end
      end
      OP_STEP: h_new = h_step;
      OP_STEP_U: begin
        h_new   = h_step;
        trk_new = step_dir ? (cmd_q.track_value - 8'd1) : (cmd_q.track_value + 8'd1);
      end
      OP_STEP_IN, OP_STEP_INU: begin
        if (nib == OP_STEP_INU) trk_new = cmd_q.track_value + 8'd1;
        if ($signed(h_cur) < $signed(trk16)) h_new = h_cur + 16'd1;
        dir_new = 1'b0;
      end
      OP_STEP_OUT, OP_STEP_OTU: begin
        if (nib == OP_STEP_OTU) trk_new = cmd_q.track_value - 8'd1;
        if ($signed(h_cur) > 0) h_new = h_cur - 16'd1;
        dir_new = 1'b1;
      end
      default: ;
    endcase
  end

  // Result assembly
  logic [9:0]  ratio;
  logic [15:0] adv;
  logic        t1_err, sec_err, force_new;
  res_t        r;
  assign ratio = (c.sbytes == 11'd0) ? 10'd0 : quo_q;
  assign adv   = cmd_q.dma_sector_count * {8'b0, ratio[7:0]};
  assign t1_err  = (h_new != {8'b0, trk_new}) && cmd_q.command_byte[2];
  assign sec_err = !is_xfer || !ok || (h_cur != {8'b0, cmd_q.track_value});

  always_comb begin
    force_new = force_flag;
    if (is_force) begin
      if (cmd_q.command_byte == CMD_FORCE_SET) begin
        force_new = 1'b1;
      end else if (cmd_q.command_byte == CMD_FORCE_CLR) begin
        force_new = 1'b0;
      end
    end

    r                 = '0;
    r.status_value    = ST_MOTOR;
    r.track_out       = cmd_q.track_value;
    r.sector_out      = cmd_q.sector_value;
    r.dma_address_out = cmd_q.dma_address;
    r.dma_count_out   = cmd_q.dma_sector_count;
    r.drive_index     = drv_ok ? {1'b0, drv_b} : DRV_NONE;
    r.force_int_flag  = force_new;

    priority if (is_t1) begin
      if (drv_ok) begin
        r.track_out    = trk_new;
        r.status_value = r.status_value | ST_SPINUP
                         | ((h_new == 16'd0) ? ST_TRACK0 : 8'h00)
                         | (t1_err ? ST_ERROR : 8'h00);
      end else begin
        r.status_value = r.status_value | ST_ERROR;
      end
    end else if (is_force) begin
      r.status_value = ST_MOTOR;
    end else if (!drv_ok) begin
      r.status_value = r.status_value | ST_ERROR;
    end else begin
      if (sec_err) r.status_value = r.status_value | ST_ERROR;
      if (is_xfer) begin
        r.dma_done      = 1'b1;
        r.transfer_kind = (nib < OP_WR_SINGL) ? XFER_READ : XFER_WRITE;
        r.byte_offset   = off_q;
        r.byte_count    = {cmd_q.dma_sector_count, {BLOCK_SHIFT{1'b0}}};
        if (ok) begin
          if (is_multi) r.sector_out = cmd_q.sector_value + adv[7:0];
          r.dma_address_out = (cmd_q.dma_address + DMA_W'(r.byte_count)) & DMA_MASK;
          r.dma_count_out   = '0;
        end
      end
    end
  end

  // Commit: state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DRIVES; d++) head[d] <= '0;
      step_dir   <= 1'b0;
      force_flag <= 1'b0;
    end else if (ctl.commit) begin
      if (is_t1 && drv_ok) begin
        head[hidx] <= h_new;
        step_dir   <= dir_new;
      end
      force_flag <= force_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) res <= r;
  end

endmodule

// ===== hw/rtl/floppy_controller_command_exec.sv =====
// ----------------------------------------------------------------------------
// floppy_controller_command_exec: floppy controller command executor
// One controller command per beat: head stepping, force interrupt and
// sector transfer description with DMA register update.
//
//   channel   dir  handshake             payload
//   command   in   valid/ready           cmd_t (command and register values)
//   result    out  valid/ready           res_t (status, registers, transfer)
//   apb       in   psel/penable/pwrite   geometry registers, 4-byte stride
//
// From its beat a command runs 5 steps of the radix-4 divider forming
// 512 / sector size, then a commit that writes its result register.
// The next command is taken in the cycle after the commit, also while the
// previous result still waits in the output register; one in flight blocks it.
// A result not yet taken holds the commit; reset clears head positions,
// step direction and force-interrupt flag; no clearing pass.
// ----------------------------------------------------------------------------
module floppy_controller_command_exec import fdc_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fdc_cmd_if.sink           command,
  fdc_res_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t [1:0] cfg;
  dp_ctl_t    ctl;
  res_t       res;

  assign pready = 1'b1;

  // Geometry registers
  fdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Sequencer
  fdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (command.valid),
    .in_ready  (command.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  // Datapath
  fdc_dp #(
    .NUM_DRIVES (NUM_DRIVES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cmd_in (command.item),
    .cfg    (cfg),
    .res    (res)
  );

  assign result.item = res;

`ifndef SYNTHESIS
  // A taken command keeps the block busy for at least the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    command.valid && command.ready |=> !command.ready)
    else $error("command taken while previous one in flight");

  // DMA done flag marks exactly the transfer results
  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.item.dma_done == (result.item.transfer_kind != XFER_NONE)))
    else $error("dma_done disagrees with transfer kind");

  // No transfer means no offset and no count
  a_no_xfer_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.item.transfer_kind == XFER_NONE |->
      result.item.byte_count == 17'd0 && result.item.byte_offset == 32'd0)
    else $error("offset or count without transfer");

  // No drive selected: nothing transferred
  a_no_drive: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.item.drive_index == DRV_NONE |->
      result.item.transfer_kind == XFER_NONE && !result.item.dma_done)
    else $error("transfer without a selected drive");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: floppy controller command executor
// Drives command beats and APB geometry writes into the executor, keeps a
// shadow copy of head positions, step direction, force-interrupt flag and
// drive geometry, and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import fdc_pkg::*;

  // Command nibbles and select patterns not named in the package
  localparam logic [3:0] OP_RD_SINGLE = 4'h8;
  localparam logic [3:0] OP_RD_ADDR   = 4'hC;
  localparam logic [3:0] OP_RD_TRACK  = 4'hE;
  localparam logic [3:0] OP_WR_TRACK  = 4'hF;
  localparam logic [3:0] FLAG_VERIFY  = 4'h4;
  localparam logic [3:0] FLAG_NONE    = 4'h0;

  // select lines are active low: bit0 side, bit1 drive A, bit2 drive B
  localparam logic [2:0] SEL_A0   = 3'b101;
  localparam logic [2:0] SEL_A1   = 3'b100;
  localparam logic [2:0] SEL_B0   = 3'b011;
  localparam logic [2:0] SEL_B1   = 3'b010;
  localparam logic [2:0] SEL_NONE = 3'b111;
  localparam logic [2:0] SEL_BOTH = 3'b001;

  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 290;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTED  = 40;

  // --------------------------------------------------------------------------
  // Shadow of the controller: state, geometry and the results still owed
  // --------------------------------------------------------------------------
  class fdc_shadow;
    logic [15:0] head_pos [2];
    bit          step_out;
    bit          force_int;
    logic [1:0]  sides    [2];
    logic [7:0]  tracks   [2];
    logic [5:0]  sectors  [2];
    logic [10:0] sbytes   [2];
    res_t        pending_results [$];
    int          errors;
    int          checked;

    function new();
      for (int d = 0; d < 2; d++) begin
        head_pos[d] = '0;
        sides[d]    = RST_SIDES;
        tracks[d]   = RST_TRACKS;
        sectors[d]  = RST_SECTORS;
        sbytes[d]   = RST_BYTES;
      end
      step_out  = 1'b0;
      force_int = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function int head_signed(int d);
      return int'($signed(head_pos[d]));
    endfunction

    function logic [7:0] head_low(int d);
      return head_pos[d][7:0];
    endfunction

    // geometry register write, masked to the register widths
    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_A_SIDES:   sides[0]   = v[1:0];
        REG_A_TRACKS:  tracks[0]  = v[7:0];
        REG_A_SECTORS: sectors[0] = v[5:0];
        REG_A_BYTES:   sbytes[0]  = v[10:0];
        REG_B_SIDES:   sides[1]   = v[1:0];
        REG_B_TRACKS:  tracks[1]  = v[7:0];
        REG_B_SECTORS: sectors[1] = v[5:0];
        default:       sbytes[1]  = v[10:0];
      endcase
    endfunction

    // Work out the result of one command and advance the shadow state
    function res_t predict_result(cmd_t c);
      res_t        r;
      logic [2:0]  sel;
      logic [3:0]  op;
      logic [7:0]  status, track, sector, cnt;
      logic [23:0] addr;
      logic [31:0] hu, secs, nbytes, ratio;
      int          drv, h, trk, dir;
      r      = '0;
      sel    = ~c.select_lines;
      op     = c.command_byte[7:4];
      status = '0;
      track  = c.track_value;
      sector = c.sector_value;
      cnt    = c.dma_sector_count;
      addr   = c.dma_address;
      dir    = step_out ? -1 : 1;
      drv    = -1;
      if (sel[2:1] == 2'b01) drv = 0;
      else if (sel[2:1] == 2'b10) drv = 1;

      if (!c.command_byte[7]) begin
        // type-I: head movement
        if (drv >= 0) begin
          h   = head_signed(drv);
          trk = int'(tracks[drv]);
          case (op)
            OP_RESTORE: begin
              h     = 0;
              track = '0;
            end
            OP_SEEK: begin
              head_pos[drv] = 16'(h + int'(c.data_value) - int'(track));
              h     = head_signed(drv);
              track = c.data_value;
              if (h < 0 || h >= trk) h = 0;
            end
            OP_STEP_U: begin
              track = track + 8'(dir);
              h     = h + dir;
            end
            OP_STEP: h = h + dir;
            OP_STEP_INU: begin
              track = track + 8'd1;
              if (h < trk) h = h + 1;
              step_out = 1'b0;
            end
            OP_STEP_IN: begin
              if (h < trk) h = h + 1;
              step_out = 1'b0;
            end
            OP_STEP_OTU: begin
              track = track - 8'd1;
              if (h > 0) h = h - 1;
              step_out = 1'b1;
            end
            default: begin
              // step out, no track update
              if (h > 0) h = h - 1;
              step_out = 1'b1;
            end
          endcase
          head_pos[drv] = 16'(h);
          h = head_signed(drv);
          if (h == 0) status |= ST_TRACK0;
          if (h != int'(track) && c.command_byte[2]) status |= ST_ERROR;
          status |= ST_SPINUP;
        end else begin
          status |= ST_ERROR;
        end
      end else if (op == OP_FORCE) begin
        if (c.command_byte == CMD_FORCE_SET) force_int = 1'b1;
        else if (c.command_byte == CMD_FORCE_CLR) force_int = 1'b0;
      end else if (drv >= 0) begin
        hu   = 32'(head_signed(drv));
        secs = 32'(sectors[drv]);
        if (op <= OP_WR_MULTI) begin
          // sector read or write
          nbytes            = 32'(cnt) * 32'd512;
          r.byte_offset     = 32'(sbytes[drv]) * (secs * 32'(sides[drv]) * hu
                              + secs * 32'(sel[0]) + (32'(sector) - 32'd1));
          r.byte_count      = nbytes[16:0];
          r.transfer_kind   = (op < OP_WR_SINGL) ? XFER_READ : XFER_WRITE;
          r.dma_done        = 1'b1;
          if (c.medium_ok) begin
            if (op == OP_RD_MULTI || op == OP_WR_MULTI) begin
              ratio  = (sbytes[drv] != '0) ? 32'd512 / 32'(sbytes[drv]) : 32'd0;
              sector = sector + 8'(32'(cnt) * ratio);
            end
            addr = (addr + nbytes[23:0]) & DMA_MASK;
            cnt  = '0;
          end else begin
            status |= ST_ERROR;
          end
        end else begin
          status |= ST_ERROR;
        end
        if (head_signed(drv) != int'(track)) status |= ST_ERROR;
      end else begin
        status |= ST_ERROR;
      end

      r.status_value    = status | ST_MOTOR;
      r.track_out       = track;
      r.sector_out      = sector;
      r.dma_address_out = addr;
      r.dma_count_out   = cnt;
      r.drive_index     = (drv < 0) ? DRV_NONE : 2'(drv);
      r.force_int_flag  = force_int;
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_results.push_back(predict_result(c));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.status_value !== want.status_value)
        report($sformatf("status_value got %0h want %0h", got.status_value,
                         want.status_value));
      if (got.track_out !== want.track_out)
        report($sformatf("track_out got %0h want %0h", got.track_out, want.track_out));
      if (got.sector_out !== want.sector_out)
        report($sformatf("sector_out got %0h want %0h", got.sector_out, want.sector_out));
      if (got.dma_address_out !== want.dma_address_out)
        report($sformatf("dma_address_out got %0h want %0h", got.dma_address_out,
                         want.dma_address_out));
      if (got.dma_count_out !== want.dma_count_out)
        report($sformatf("dma_count_out got %0h want %0h", got.dma_count_out,
                         want.dma_count_out));
      if (got.dma_done !== want.dma_done)
        report($sformatf("dma_done got %0h want %0h", got.dma_done, want.dma_done));
      if (got.transfer_kind !== want.transfer_kind)
        report($sformatf("transfer_kind got %0h want %0h", got.transfer_kind,
                         want.transfer_kind));
      if (got.byte_offset !== want.byte_offset)
        report($sformatf("byte_offset got %0h want %0h", got.byte_offset,
                         want.byte_offset));
      if (got.byte_count !== want.byte_count)
        report($sformatf("byte_count got %0h want %0h", got.byte_count, want.byte_count));
      if (got.drive_index !== want.drive_index)
        report($sformatf("drive_index got %0h want %0h", got.drive_index,
                         want.drive_index));
      if (got.force_int_flag !== want.force_int_flag)
        report($sformatf("force_int_flag got %0h want %0h", got.force_int_flag,
                         want.force_int_flag));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fdc_cmd_if cmd_if ();
  fdc_res_if res_if ();

  fdc_shadow sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int geometries    = 1;

  floppy_controller_command_exec uut (
    .clk     (clk),
    .rst     (rst),
    .command (cmd_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: take beats with random back-pressure
  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.item);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task send_cmd(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.item  <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_command(c);
    items_sent++;
  endtask

  // hold the command side until every owed result has been taken
  task drain();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task program_drive(input bit d, input int s, input int t, input int n, input int b);
    apb_write(d ? REG_B_SIDES   : REG_A_SIDES,   32'(s));
    apb_write(d ? REG_B_TRACKS  : REG_A_TRACKS,  32'(t));
    apb_write(d ? REG_B_SECTORS : REG_A_SECTORS, 32'(n));
    apb_write(d ? REG_B_BYTES   : REG_A_BYTES,   32'(b));
  endtask

  // sector size: powers of two for half the picks, else any size from 128 to 1024
  function int pick_sector_bytes();
    if ($urandom_range(1) == 0) return 128 << $urandom_range(3);
    return $urandom_range(1024, 128);
  endfunction

  function cmd_t mk(logic [7:0] cmd, logic [7:0] data, logic [7:0] track,
                    logic [7:0] sector, logic [2:0] sel, logic [23:0] addr,
                    logic [7:0] cnt, bit ok);
    cmd_t c;
    c.command_byte     = cmd;
    c.data_value       = data;
    c.track_value      = track;
    c.sector_value     = sector;
    c.select_lines     = sel;
    c.dma_address      = addr;
    c.dma_sector_count = cnt;
    c.medium_ok        = ok;
    return c;
  endfunction

  // Random command: mostly a single drive, track register mostly in step
  // with the head so that sector commands get past the position check
  function cmd_t random_cmd();
    cmd_t       c;
    int         pick, d;
    logic [3:0] op, low;
    pick = $urandom_range(99);
    if (pick < 45)      c.select_lines = {2'b10, 1'($urandom_range(1))};
    else if (pick < 90) c.select_lines = {2'b01, 1'($urandom_range(1))};
    else                c.select_lines = 3'($urandom_range(7));
    d    = (c.select_lines[2:1] == 2'b01) ? 1 : 0;
    low  = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 35) op = 4'($urandom_range(7));
    else if (pick < 42) begin
      op = OP_FORCE;
      if ($urandom_range(1) == 0)
        low = $urandom_range(1) ? CMD_FORCE_SET[3:0] : CMD_FORCE_CLR[3:0];
    end else if (pick < 92) op = 4'($urandom_range(OP_WR_MULTI, OP_RD_SINGLE));
    else begin
      pick = $urandom_range(2);
      op   = (pick == 0) ? OP_RD_ADDR : (pick == 1) ? OP_RD_TRACK : OP_WR_TRACK;
    end
    c.command_byte     = {op, low};
    c.data_value       = ($urandom_range(99) < 60) ? 8'($urandom_range(90))
                                                   : 8'($urandom_range(255));
    c.track_value      = ($urandom_range(99) < 75) ? sb.head_low(d)
                                                   : 8'($urandom_range(255));
    c.sector_value     = ($urandom_range(99) < 70) ? 8'($urandom_range(20, 1))
                                                   : 8'($urandom_range(255));
    c.dma_address      = 24'($urandom);
    c.dma_sector_count = ($urandom_range(99) < 70) ? 8'($urandom_range(8))
                                                   : 8'($urandom_range(255));
    c.medium_ok        = ($urandom_range(99) < 85);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int send_idle_by_phase [NUM_PHASES] = '{0, 65, 0, 30, 65, 30};
  int stall_by_phase     [NUM_PHASES] = '{0, 0, 65, 30, 0, 30};

  initial begin : stimulus
    rst          <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.item  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // geometry changes only with nothing in flight
      case (p)
        0: ;
        1: begin
          program_drive(1'b0, 1, 1, 1, 128);
          program_drive(1'b1, 2, 255, 63, 1024);
        end
        2: begin
          program_drive(1'b0, 2, 255, 63, 1024);
          program_drive(1'b1, 1, 1, 1, 128);
        end
        default: begin
          program_drive(1'b0, $urandom_range(2, 1), $urandom_range(255, 1),
                        $urandom_range(63, 1), pick_sector_bytes());
          program_drive(1'b1, $urandom_range(2, 1), $urandom_range(255, 1),
                        $urandom_range(63, 1), pick_sector_bytes());
        end
      endcase
      if (p > 0) geometries++;
      send_idle_pct = send_idle_by_phase[p];
      stall_pct     = stall_by_phase[p];

      if (p == 0) begin
        // head movement on drive A, verify both passing and failing
        send_cmd(mk({OP_RESTORE, FLAG_VERIFY}, 8'h00, 8'h55, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk({OP_SEEK, FLAG_VERIFY}, 8'd10, 8'd0, 8'h01, SEL_A0, '0, 8'd0, 1));
        // seek past the last track puts the head back on zero
        send_cmd(mk({OP_SEEK, FLAG_VERIFY}, 8'hFF, 8'd10, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk({OP_STEP_INU, FLAG_VERIFY}, 8'h00, 8'd0, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk({OP_STEP, 4'hF}, 8'h00, 8'd1, 8'h01, SEL_A1, '0, 8'd0, 1));
        send_cmd(mk({OP_STEP_OTU, FLAG_VERIFY}, 8'h00, 8'd2, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk({OP_STEP_U, FLAG_VERIFY}, 8'h00, 8'd1, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk({OP_STEP_OUT, FLAG_NONE}, 8'h00, 8'd0, 8'h01, SEL_A0, '0, 8'd0, 1));
        // step outward from zero: head goes negative
        send_cmd(mk({OP_STEP, FLAG_VERIFY}, 8'h00, 8'd0, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk({OP_RD_SINGLE, FLAG_NONE}, 8'h00, 8'd0, 8'h01, SEL_A0, 24'h1000, 8'd1, 1));
        send_cmd(mk({OP_RESTORE, FLAG_NONE}, 8'h00, 8'd7, 8'h01, SEL_A0, '0, 8'd0, 1));
        // sector transfers: success, wrap of address, failed medium
        send_cmd(mk({OP_RD_SINGLE, FLAG_NONE}, 8'h00, 8'd0, 8'h01, SEL_A0, 24'h0, 8'd1, 1));
        send_cmd(mk({OP_RD_MULTI, FLAG_NONE}, 8'hFF, 8'd0, 8'hFF, SEL_A1, 24'hFFFFFF,
                    8'hFF, 1));
        // sector zero wraps in the offset sum
        send_cmd(mk({OP_WR_SINGL, FLAG_NONE}, 8'h00, 8'd0, 8'h00, SEL_A0, 24'h123456,
                    8'd3, 0));
        send_cmd(mk({OP_WR_MULTI, FLAG_NONE}, 8'h00, sb.head_low(1), 8'd9, SEL_B1,
                    24'hFFFE00, 8'd2, 1));
        send_cmd(mk({OP_RD_ADDR, FLAG_NONE}, 8'h00, 8'd0, 8'h01, SEL_A0, 24'hABCDEF,
                    8'd4, 1));
        send_cmd(mk({OP_RD_TRACK, FLAG_VERIFY}, 8'h00, 8'd0, 8'h01, SEL_B0, '0, 8'd4, 1));
        send_cmd(mk({OP_WR_TRACK, FLAG_NONE}, 8'h00, 8'd3, 8'h01, SEL_A0, '0, 8'd4, 1));
        // force interrupt: set, other codes leave it, clear
        send_cmd(mk(CMD_FORCE_SET, 8'h00, 8'd0, 8'h01, SEL_NONE, '0, 8'd0, 1));
        send_cmd(mk({OP_FORCE, 4'h3}, 8'h00, 8'd0, 8'h01, SEL_A0, '0, 8'd0, 1));
        send_cmd(mk(CMD_FORCE_CLR, 8'h00, 8'd0, 8'h01, SEL_BOTH, '0, 8'd0, 1));
        send_cmd(mk({OP_FORCE, 4'hF}, 8'h00, 8'd0, 8'h01, SEL_B0, '0, 8'd0, 1));
        // no drive and both drives selected
        send_cmd(mk({OP_RD_SINGLE, FLAG_NONE}, 8'h00, 8'd0, 8'h01, SEL_NONE, 24'h10,
                    8'd1, 1));
        send_cmd(mk({OP_SEEK, FLAG_VERIFY}, 8'd5, 8'd0, 8'h01, SEL_BOTH, '0, 8'd0, 1));
        send_cmd(mk(8'h7F, 8'h00, 8'hFF, 8'h01, SEL_B0, '0, 8'd0, 1));
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) == 0) drain();
        send_cmd(random_cmd());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("summary: %0d commands over %0d phases and %0d geometry settings",
             items_sent, NUM_PHASES, geometries);
    $display("summary: %0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
